>>> hw/rtl/qssf_pkg.sv
// Shared constants, types and helpers for the quick search substring finder.
// No dependencies; the top level refers to it by scoped names.
package qssf_pkg;

   // Storage sizes.
   localparam int TEXT_DEPTH  = 4096;
   localparam int MAX_PATTERN = 32;
   localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
   localparam int TCNT_W      = TEXT_AW + 1;
   localparam int PIDX_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // Field and register widths.
   localparam int BYTE_W     = 8;
   localparam int PLEN_W     = 6;
   localparam int SHIFT_W    = 6;
   localparam int OFFSET_W   = 12;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int PAT_WORDS  = 4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IGNORE_CASE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_THIRD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd5;

   // ASCII letter bounds for case folding.
   localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] ASCII_CASE    = 8'h20;

   typedef logic [PAT_WORDS-1:0][CSR_DATA_W-1:0] pattern_words_type;

   // Folds an upper-case ASCII letter to lower case when enabled.
   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                   input logic en);
      logic [BYTE_W-1:0] r;
      r = c;
      if (en && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
         r = c + ASCII_CASE;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/quick_search_substring_finder.sv
// Quick search substring finder: text buffer, shift table and search sequencer.
// Depends on qssf_pkg for sizes, register indexes and the case-folding helper.
//
//   channel | direction | signals                                         | handshake
//   req     | in        | req_text_byte, req_last_byte                    | req_valid/req_ready
//   rsp     | out       | rsp_found, rsp_match_offset, rsp_text_overflow  | rsp_valid/rsp_ready
//   csr     | in        | csr_index, csr_write_data                       | csr_write_enable
//
// Text bytes without the last flag are accepted back to back.
// The last byte starts the search: the shift table is preset, the pattern bytes are
// entered, then text bytes are compared one by one and the window shifts by the
// lookahead byte's entry, all through one text read port and one shift table read port.
// Reset is synchronous and clears control and configuration state, not the memories.
// A finished item waits in the output register; the next text streams in meanwhile.
module quick_search_substring_finder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [qssf_pkg::BYTE_W-1:0]         req_text_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [qssf_pkg::OFFSET_W-1:0]       rsp_match_offset,
   output logic                                rsp_text_overflow,
   input  logic                                csr_write_enable,
   input  logic [qssf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qssf_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int TAW  = qssf_pkg::TEXT_AW;
   localparam int TCW  = qssf_pkg::TCNT_W;
   localparam int BW   = qssf_pkg::BYTE_W;
   localparam int PLW  = qssf_pkg::PLEN_W;
   localparam int SHW  = qssf_pkg::SHIFT_W;
   localparam int OFW  = qssf_pkg::OFFSET_W;
   localparam int PIW  = qssf_pkg::PIDX_W;
   localparam int MAXP = qssf_pkg::MAX_PATTERN;
   localparam int PAT_BITS_W = qssf_pkg::PAT_WORDS * qssf_pkg::CSR_DATA_W;

   // Sequencer states.
   localparam logic [3:0] S_LOAD    = 4'd0;
   localparam logic [3:0] S_CLEAR   = 4'd1;
   localparam logic [3:0] S_FILL    = 4'd2;
   localparam logic [3:0] S_START   = 4'd3;
   localparam logic [3:0] S_RD      = 4'd4;
   localparam logic [3:0] S_CHK     = 4'd5;
   localparam logic [3:0] S_LA_RD   = 4'd6;
   localparam logic [3:0] S_LA_WAIT = 4'd7;
   localparam logic [3:0] S_SHIFT   = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   // Configuration registers.
   logic [PLW-1:0]                  pattern_length_ff;
   logic                            ignore_case_ff;
   qssf_pkg::pattern_words_type     pattern_words_ff;

   // Control registers and next values.
   logic [3:0]      state_ff, state_in;
   logic [TCW-1:0]  text_count_ff, text_count_in;
   logic            overflow_seen_ff, overflow_seen_in;
   logic [TCW-1:0]  window_start_ff, window_start_in;
   logic [PLW-1:0]  compare_index_ff, compare_index_in;
   logic [PLW-1:0]  len_ff, len_in;
   logic [BW-1:0]   clear_index_ff, clear_index_in;
   logic            hit_ff, hit_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_found_ff, rsp_found_in;
   logic [OFW-1:0]  rsp_offset_ff, rsp_offset_in;
   logic            rsp_overflow_ff, rsp_overflow_in;

   // Memories and their registered read data.
   logic [BW-1:0]   text_mem [qssf_pkg::TEXT_DEPTH];
   logic [SHW-1:0]  shift_mem [2**BW];
   logic [BW-1:0]   text_rd_ff;
   logic [SHW-1:0]  shift_rd_ff;

   // Datapath signals.
   logic [PAT_BITS_W-1:0]       pattern_flat;
   logic [MAXP-1:0][BW-1:0]     pattern_bytes;
   logic [BW-1:0]               pattern_byte;
   logic [BW-1:0]               text_folded;
   logic [PLW-1:0]              eff_length;
   logic [TCW:0]                window_end;
   logic [TCW-1:0]              text_rd_sum;
   logic [TAW-1:0]              text_rd_addr;
   logic                        text_we;
   logic                        shift_we;
   logic [BW-1:0]               shift_waddr;
   logic [SHW-1:0]              shift_wdata;
   logic [OFW+TCW-1:0]          offset_wide;
   logic                        req_fire;

   // Pattern byte view, selected by the shared compare index.
   assign pattern_flat  = pattern_words_ff;
   assign pattern_bytes = pattern_flat[MAXP*BW-1:0];
   assign pattern_byte  = qssf_pkg::fold_byte(pattern_bytes[compare_index_ff[PIW-1:0]],
                                              ignore_case_ff);
   assign text_folded   = qssf_pkg::fold_byte(text_rd_ff, ignore_case_ff);

   // Pattern length clamped into the supported range.
   always_comb begin
      eff_length = pattern_length_ff;
      if (pattern_length_ff == '0) begin
         eff_length = PLW'(1);
      end else if (pattern_length_ff > PLW'(MAXP)) begin
         eff_length = PLW'(MAXP);
      end
   end

   // Window end, and the text read address for compare or lookahead.
   assign window_end   = {1'b0, window_start_ff} + (TCW+1)'(len_ff);
   assign text_rd_sum  = (state_ff == S_LA_RD) ? (window_start_ff + TCW'(len_ff))
                                               : (window_start_ff + TCW'(compare_index_ff));
   assign text_rd_addr = text_rd_sum[TAW-1:0];

   assign req_ready = (state_ff == S_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign text_we   = req_fire && (text_count_ff < TCW'(qssf_pkg::TEXT_DEPTH));

   // Shift table write port: preset sweep, then one entry per pattern byte.
   assign shift_we    = (state_ff == S_CLEAR) || (state_ff == S_FILL);
   assign shift_waddr = (state_ff == S_CLEAR) ? clear_index_ff : pattern_byte;
   assign shift_wdata = (state_ff == S_CLEAR) ? SHW'(len_ff + PLW'(1))
                                              : SHW'(len_ff - compare_index_ff);

   assign offset_wide = {{OFW{1'b0}}, window_start_ff};

   // Sequencer next-state logic.
   always_comb begin
      state_in         = state_ff;
      text_count_in    = text_count_ff;
      overflow_seen_in = overflow_seen_ff;
      window_start_in  = window_start_ff;
      compare_index_in = compare_index_ff;
      len_in           = len_ff;
      clear_index_in   = clear_index_ff;
      hit_in           = hit_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_found_in     = rsp_found_ff;
      rsp_offset_in    = rsp_offset_ff;
      rsp_overflow_in  = rsp_overflow_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (text_we) begin
                  text_count_in = text_count_ff + TCW'(1);
               end else begin
                  overflow_seen_in = 1'b1;
               end
               if (req_last_byte) begin
                  len_in           = eff_length;
                  clear_index_in   = '0;
                  window_start_in  = '0;
                  compare_index_in = '0;
                  hit_in           = 1'b0;
                  state_in         = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            clear_index_in = clear_index_ff + BW'(1);
            if (clear_index_ff == {BW{1'b1}}) begin
               compare_index_in = '0;
               state_in         = S_FILL;
            end
         end
         S_FILL: begin
            // Later positions overwrite earlier ones, so the last one wins.
            if (compare_index_ff == len_ff - PLW'(1)) begin
               compare_index_in = '0;
               state_in         = S_START;
            end else begin
               compare_index_in = compare_index_ff + PLW'(1);
            end
         end
         S_START: begin
            compare_index_in = '0;
            if (window_end <= {1'b0, text_count_ff}) begin
               state_in = S_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (text_folded == pattern_byte) begin
               if (compare_index_ff == len_ff - PLW'(1)) begin
                  hit_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  compare_index_in = compare_index_ff + PLW'(1);
                  state_in         = S_RD;
               end
            end else if (window_end >= {1'b0, text_count_ff}) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LA_RD;
            end
         end
         S_LA_RD: begin
            state_in = S_LA_WAIT;
         end
         S_LA_WAIT: begin
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            window_start_in = window_start_ff + TCW'(shift_rd_ff);
            state_in        = S_START;
         end
         S_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_found_in     = hit_ff;
               rsp_offset_in    = hit_ff ? offset_wide[OFW-1:0] : '0;
               rsp_overflow_in  = overflow_seen_ff;
               text_count_in    = '0;
               overflow_seen_in = 1'b0;
               state_in         = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Control and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_LOAD;
         text_count_ff    <= '0;
         overflow_seen_ff <= 1'b0;
         window_start_ff  <= '0;
         compare_index_ff <= '0;
         len_ff           <= PLW'(1);
         clear_index_ff   <= '0;
         hit_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         text_count_ff    <= text_count_in;
         overflow_seen_ff <= overflow_seen_in;
         window_start_ff  <= window_start_in;
         compare_index_ff <= compare_index_in;
         len_ff           <= len_in;
         clear_index_ff   <= clear_index_in;
         hit_ff           <= hit_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_found_ff    <= rsp_found_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= PLW'(1);
         ignore_case_ff    <= 1'b0;
         pattern_words_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            qssf_pkg::REG_PATTERN_LENGTH: pattern_length_ff <= csr_write_data[PLW-1:0];
            qssf_pkg::REG_IGNORE_CASE:    ignore_case_ff    <= csr_write_data[0];
            qssf_pkg::REG_PATTERN_LOW:    pattern_words_ff[0] <= csr_write_data;
            qssf_pkg::REG_PATTERN_SECOND: pattern_words_ff[1] <= csr_write_data;
            qssf_pkg::REG_PATTERN_THIRD:  pattern_words_ff[2] <= csr_write_data;
            qssf_pkg::REG_PATTERN_HIGH:   pattern_words_ff[3] <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Text buffer: one write port for loading, one registered read port.
   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[text_count_ff[TAW-1:0]] <= req_text_byte;
      end
      text_rd_ff <= text_mem[text_rd_addr];
   end

   // Shift table, read at the folded lookahead byte.
   always_ff @(posedge clock) begin
      if (shift_we) begin
         shift_mem[shift_waddr] <= shift_wdata;
      end
      shift_rd_ff <= shift_mem[text_folded];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_offset  = rsp_offset_ff;
   assign rsp_text_overflow = rsp_overflow_ff;

   // The buffer count never passes the buffer depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      text_count_ff <= TCW'(qssf_pkg::TEXT_DEPTH))
      else $error("text count beyond buffer depth");

   // Every compare reads inside the stored text.
   a_window_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> (window_end <= {1'b0, text_count_ff}))
      else $error("compare window runs past stored text");

   // A new result only comes out of the hand-over state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside hand-over");

   // A waiting result is not overwritten.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_offset_ff)
                                         && $stable(rsp_found_ff)))
      else $error("pending result changed");

   // A miss reports offset zero.
   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_offset_ff == '0))
      else $error("miss with nonzero offset");

endmodule

>>> verif/quick_search_substring_finder_tb.sv
// Self-checking testbench for the quick search substring finder.
// Predicts each search result from its own model of the block; needs qssf_pkg
// and quick_search_substring_finder.
`timescale 1ns / 100ps

module quick_search_substring_finder_tb;

   typedef logic [qssf_pkg::BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic                          found;
      logic [qssf_pkg::OFFSET_W-1:0] offset;
      logic                          overflow;
   } search_result_type;

   localparam byte_type UPPER_A  = 8'h41;
   localparam byte_type UPPER_Z  = 8'h5A;
   localparam byte_type LOWER_A  = 8'h61;
   localparam byte_type LOWER_Z  = 8'h7A;
   localparam byte_type CASE_BIT = 8'h20;

   localparam int IDLE_PERCENT = 13;
   localparam int LONG_STALL   = 800;
   localparam int SETTLE       = 8;
   localparam int QUIET_LIMIT  = 200_000;
   localparam int LONG_TEXT    = 150;
   localparam int PHASE_BYTES  = 45;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   byte_type req_text_byte = '0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_found;
   logic [qssf_pkg::OFFSET_W-1:0] rsp_match_offset;
   logic rsp_text_overflow;
   logic csr_write_enable = 1'b0;
   logic [qssf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [qssf_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   // Model of the block's configuration and text buffer.
   logic [qssf_pkg::PLEN_W-1:0]     length_cfg = 1;
   logic                            fold_cfg = 1'b0;
   logic [qssf_pkg::CSR_DATA_W-1:0] pattern_cfg [qssf_pkg::PAT_WORDS] = '{default: '0};
   byte_type                        text_copy [qssf_pkg::TEXT_DEPTH];
   int                              text_len = 0;
   bit                              text_dropped = 1'b0;

   search_result_type pending_results [$];
   byte_type          text_q [$];
   search_result_type oldest;
   int                error_count = 0;
   int                quiet_cycles = 0;

   // Idling and receiver hold-off control.
   bit idling_on = 1'b1;
   int rsp_stall_count = 0;
   int rsp_stall_seen = 0;
   int rsp_hold_left = 0;

   quick_search_substring_finder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_text_overflow (rsp_text_overflow),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Search model
   // ------------------------------------------------------------------

   function automatic byte_type fold_case(input byte_type c);
      if (fold_cfg && c >= UPPER_A && c <= UPPER_Z) begin
         return c + CASE_BIT;
      end
      return c;
   endfunction

   function automatic byte_type pattern_raw(input int i);
      return pattern_cfg[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic byte_type pattern_at(input int i);
      return fold_case(pattern_raw(i));
   endfunction

   // Out-of-range lengths are clamped into 1..MAX_PATTERN.
   function automatic int pattern_span();
      int n;
      n = length_cfg;
      if (n < 1) n = 1;
      if (n > qssf_pkg::MAX_PATTERN) n = qssf_pkg::MAX_PATTERN;
      return n;
   endfunction

   // Sunday quick search over the stored text.
   function automatic search_result_type first_occurrence();
      int shift_by [256];
      int n;
      int pos;
      int k;
      search_result_type r;
      r = '0;
      r.overflow = text_dropped;
      n = pattern_span();
      for (int c = 0; c < 256; c++) shift_by[c] = n + 1;
      for (int i = 0; i < n; i++) shift_by[pattern_at(i)] = n - i;
      pos = 0;
      while (pos + n <= text_len) begin
         k = 0;
         while (k < n && fold_case(text_copy[pos + k]) == pattern_at(k)) k++;
         if (k == n) begin
            r.found  = 1'b1;
            r.offset = pos[qssf_pkg::OFFSET_W-1:0];
            return r;
         end
         if (pos + n >= text_len) break;
         pos += shift_by[fold_case(text_copy[pos + n])];
      end
      return r;
   endfunction

   // Stores an accepted byte; bytes past the buffer are dropped and flagged.
   function automatic void take_text_byte(input byte_type value, input bit is_last);
      if (text_len < qssf_pkg::TEXT_DEPTH) begin
         text_copy[text_len] = value;
         text_len++;
      end else begin
         text_dropped = 1'b1;
      end
      if (is_last) begin
         pending_results.push_back(first_occurrence());
         text_len     = 0;
         text_dropped = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   task automatic send_byte(input byte_type value, input bit is_last);
      if (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= value;
      req_last_byte <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      take_text_byte(value, is_last);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic send_string(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      send_text();
   endtask

   // Sender stops and waits until every search has reported.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [qssf_pkg::CSR_IDX_W-1:0] index,
                                 input logic [qssf_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (index)
         qssf_pkg::REG_PATTERN_LENGTH: length_cfg = value[qssf_pkg::PLEN_W-1:0];
         qssf_pkg::REG_IGNORE_CASE:    fold_cfg = value[0];
         qssf_pkg::REG_PATTERN_LOW:    pattern_cfg[0] = value;
         qssf_pkg::REG_PATTERN_SECOND: pattern_cfg[1] = value;
         qssf_pkg::REG_PATTERN_THIRD:  pattern_cfg[2] = value;
         qssf_pkg::REG_PATTERN_HIGH:   pattern_cfg[3] = value;
         default: ;
      endcase
   endtask

   // Registers are only written once the block has gone idle.
   task automatic configure(input logic [qssf_pkg::CSR_DATA_W-1:0] len,
                            input logic fold,
                            input logic [qssf_pkg::CSR_DATA_W-1:0] w0,
                            input logic [qssf_pkg::CSR_DATA_W-1:0] w1,
                            input logic [qssf_pkg::CSR_DATA_W-1:0] w2,
                            input logic [qssf_pkg::CSR_DATA_W-1:0] w3);
      drain_results();
      write_register(qssf_pkg::REG_PATTERN_LENGTH, len);
      write_register(qssf_pkg::REG_IGNORE_CASE, {63'b0, fold});
      write_register(qssf_pkg::REG_PATTERN_LOW, w0);
      write_register(qssf_pkg::REG_PATTERN_SECOND, w1);
      write_register(qssf_pkg::REG_PATTERN_THIRD, w2);
      write_register(qssf_pkg::REG_PATTERN_HIGH, w3);
   endtask

   // ------------------------------------------------------------------
   // Random content
   // ------------------------------------------------------------------

   // Letters of both cases plus the neighbors of the folding range.
   function automatic byte_type pick_symbol();
      case ($urandom_range(7))
         0: return "a";
         1: return "b";
         2: return "A";
         3: return "B";
         4: return "Z";
         5: return "z";
         6: return "@";
         default: return "[";
      endcase
   endfunction

   function automatic logic [qssf_pkg::CSR_DATA_W-1:0] random_pattern_word();
      logic [qssf_pkg::CSR_DATA_W-1:0] w;
      for (int i = 0; i < 8; i++) begin
         w[i * 8 +: 8] = ($urandom_range(3) == 0) ? byte_type'($urandom_range(255))
                                                  : pick_symbol();
      end
      return w;
   endfunction

   // With folding on, letters may be copied in either case.
   function automatic byte_type vary_case(input byte_type c);
      if (fold_cfg && $urandom_range(1) &&
          ((c >= UPPER_A && c <= UPPER_Z) || (c >= LOWER_A && c <= LOWER_Z))) begin
         return c ^ CASE_BIT;
      end
      return c;
   endfunction

   // Mostly short texts; half of those at least as long as the pattern carry a copy of it.
   function automatic void build_random_text(input bit noisy);
      int len;
      int n;
      int at;
      text_q.delete();
      len = ($urandom_range(99) < 80) ? $urandom_range(1, 24) : $urandom_range(25, 64);
      for (int i = 0; i < len; i++) begin
         text_q.push_back(noisy ? byte_type'($urandom_range(255)) : pick_symbol());
      end
      n = pattern_span();
      if ($urandom_range(1) && n <= len) begin
         at = $urandom_range(0, len - n);
         for (int i = 0; i < n; i++) text_q[at + i] = vary_case(pattern_raw(i));
      end
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset pattern is a single zero byte.
   task automatic test_reset_defaults();
      text_q.delete();
      text_q.push_back(8'h00);
      send_text();
      text_q.delete();
      text_q.push_back(8'hFF);
      text_q.push_back(8'h00);
      send_text();
      drain_results();
   endtask

   task automatic test_directed_patterns();
      // Plain pattern "xyz" found one byte in.
      configure(3, 1'b0, 64'h7A7978, '0, '0, '0);
      send_string("wxyz");
      // Pattern "AbC" with folding matches text of mixed case.
      configure(3, 1'b1, 64'h436241, '0, '0, '0);
      send_string("xaBc");
      // The same without folding does not match.
      configure(3, 1'b0, 64'h436241, '0, '0, '0);
      send_string("xaBc");
      // Length zero is taken as one; pattern "Q" folds to "q".
      configure(0, 1'b1, 64'h51, '0, '0, '0);
      send_string("zq");
      // All-ones pattern bytes.
      configure(2, 1'b0, '1, '0, '0, '0);
      text_q.delete();
      text_q.push_back(8'hFF);
      text_q.push_back(8'hFF);
      send_text();
      // Length above the maximum is clamped; pattern longer than the text.
      configure(63, 1'b1, '1, '1, '1, '1);
      send_string("abcde");
      drain_results();
   endtask

   // A long text with the pattern at its very end, then a short one after it.
   task automatic test_long_text();
      configure(3, 1'b0, {32'b0, $urandom()}, '0, '0, '0);
      text_q.delete();
      for (int i = 0; i < LONG_TEXT - 3; i++) begin
         text_q.push_back(byte_type'($urandom_range(255)));
      end
      for (int i = 0; i < 3; i++) text_q.push_back(pattern_raw(i));
      send_text();
      send_string("ab");
      drain_results();
   endtask

   // Receiver holds off while texts keep coming, so the block backs up.
   task automatic test_output_stall();
      rsp_stall_count++;
      repeat (6) begin
         build_random_text(1'b0);
         send_text();
      end
      drain_results();
   endtask

   task automatic test_random_texts();
      int sent;
      int len;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(3))
            0: len = 1;
            1: len = qssf_pkg::MAX_PATTERN;
            default: len = $urandom_range(2, 8);
         endcase
         configure(qssf_pkg::CSR_DATA_W'(len), 1'($urandom_range(1)),
                   random_pattern_word(), random_pattern_word(),
                   random_pattern_word(), random_pattern_word());
         // One phase runs without any idling on either side.
         idling_on = (phase != 3);
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_random_text($urandom_range(99) < 30);
            sent += text_q.size();
            send_text();
         end
      end
      drain_results();
      idling_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (rsp_stall_seen != rsp_stall_count) begin
         rsp_stall_seen <= rsp_stall_count;
         rsp_hold_left  <= LONG_STALL;
         rsp_ready      <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ready     <= 1'b0;
      end else if (idling_on) begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Each result is compared with the oldest predicted one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result with none expected: found %0d offset %0d overflow %0d",
                   rsp_found, rsp_match_offset, rsp_text_overflow);
            error_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_found !== oldest.found) begin
               $error("found: expected %0d, actual %0d", oldest.found, rsp_found);
               error_count++;
            end
            if (rsp_match_offset !== oldest.offset) begin
               $error("match_offset: expected %0d, actual %0d", oldest.offset,
                      rsp_match_offset);
               error_count++;
            end
            if (rsp_text_overflow !== oldest.overflow) begin
               $error("text_overflow: expected %0d, actual %0d", oldest.overflow,
                      rsp_text_overflow);
               error_count++;
            end
         end
      end
   end

   // Ends the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no item accepted for %0d cycles", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_patterns();
      test_long_text();
      test_output_stall();
      test_random_texts();
      drain_results();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
